[rtl/dstq_pkg.sv]
// ----------------------------------------------------------------------------
// dstq_pkg
// Shared types and constants for the deadline-sorted timeout queue: slot and
// time widths, stream field layout, operation and status codes, link record.
// ----------------------------------------------------------------------------
package dstq_pkg;

  // Slot count and time range
  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int TIME_BITS = 48;
  localparam int TMO_W     = 32;

  // Input request tdata layout: tag, timeout_us, now_us (low bits first)
  localparam int IN_TAG_LO = 0;
  localparam int IN_TMO_LO = IN_TAG_LO + SLOT_W;
  localparam int IN_NOW_LO = IN_TMO_LO + TMO_W;
  localparam int IN_BITS   = IN_NOW_LO + TIME_BITS;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Result tdata layout: status, head_changed, head_valid, head_tag, deadline
  localparam int STATUS_W   = 2;
  localparam int OUT_BITS   = STATUS_W + 1 + 1 + SLOT_W + TIME_BITS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes
  localparam logic OP_ARM    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_TMO   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd2;

  // One slot's neighbor links
  typedef struct packed {
    logic              pv;
    logic [SLOT_W-1:0] prv;
    logic              nv;
    logic [SLOT_W-1:0] nxt;
  } link_t;

endpackage

[rtl/deadline_sorted_timeout_queue_core.sv]
// ----------------------------------------------------------------------------
// deadline_sorted_timeout_queue_core
// Doubly linked list of command slots kept in deadline order. Arm places or
// moves a slot by a one-node-per-cycle scan; remove unlinks it. Every request
// returns one result with the current head.
// ----------------------------------------------------------------------------
//  channel | ports                         | content
//  --------+-------------------------------+---------------------------------
//  input   | in_tvalid/in_tready/in_tdata  | request: operation in tuser,
//          | in_tuser                      | tag, timeout_us, now_us in tdata
//  output  | out_tvalid/out_tready/out_tdata | status, head_changed,
//          |                               | head_valid, head_tag, deadline
//
// Steps: a request with nothing to scan or relink (zero timeout, slot not
// queued, rearm of the tail) goes straight to the head read; a remove or a
// first slot also relinks, and an arm may first scan up to the 15 other
// slots. An output stall holds the finished result until the register frees.
// The scan compares one stored deadline per cycle on the deadline RAM's
// single read port while following the link registers.
// Reset clears the queue to empty at once; the deadline store is not cleared.
// A waiting result is held in the output register; the next request is taken
// meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
module deadline_sorted_timeout_queue_core
  import dstq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // tag[3:0], timeout_us[35:4], now_us[83:36]
  input  logic                  in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[1:0], head_changed[2],
                                            // head_valid[3], head_tag[7:4],
                                            // head_deadline[55:8]
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_FSCAN, S_BSCAN, S_UNLINK, S_LAFTER, S_LHEAD, S_HRD, S_FIN
  } state_t;

  // Sequencer and request registers
  state_t                state_r, state_nxt;
  logic                  op_r, op_nxt;
  logic [SLOT_W-1:0]     tag_r, tag_nxt;
  logic                  tmo_zero_r, tmo_zero_nxt;
  logic [TIME_BITS-1:0]  dl_r, dl_nxt;
  logic [SLOT_W-1:0]     pend_r, pend_nxt;
  logic [SLOT_W-1:0]     last_r, last_nxt;
  logic                  moved_r, moved_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  changed_r, changed_nxt;

  // Queue structure
  link_t                 lk_r [SLOTS];
  link_t                 lk_nxt [SLOTS];
  logic [SLOTS-1:0]      queued_r, queued_nxt;
  logic [SLOT_W-1:0]     head_r, head_nxt;
  logic [SLOT_W-1:0]     tail_r, tail_nxt;
  logic                  empty_r, empty_nxt;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Link read port and deadline RAM
  logic [SLOT_W-1:0]     lk_addr;
  link_t                 lk_rd;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [TIME_BITS-1:0]  ram_rdata;

  // Deadline computation at request time
  logic [TIME_BITS:0]    dl_sum;

  dstq_ram #(
    .W     (TIME_BITS),
    .DEPTH (SLOTS)
  ) u_dl_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tag_r),
    .wdata (dl_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Saturating deadline add
  assign dl_sum = {1'b0, in_tdata[IN_NOW_LO +: TIME_BITS]}
                + {{(TIME_BITS + 1 - TMO_W){1'b0}}, in_tdata[IN_TMO_LO +: TMO_W]};

  // Select the one link entry read this cycle
  always_comb begin
    case (state_r)
      S_FSCAN, S_BSCAN: lk_addr = pend_r;
      S_LAFTER:         lk_addr = last_r;
      default:          lk_addr = tag_r;
    endcase
  end

  assign lk_rd = lk_r[lk_addr];

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    tag_nxt       = tag_r;
    tmo_zero_nxt  = tmo_zero_r;
    dl_nxt        = dl_r;
    pend_nxt      = pend_r;
    last_nxt      = last_r;
    moved_nxt     = moved_r;
    status_nxt    = status_r;
    changed_nxt   = changed_r;
    lk_nxt        = lk_r;
    queued_nxt    = queued_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_raddr     = head_r;

    case (state_r)
      // Take a request
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tuser;
          tag_nxt      = in_tdata[IN_TAG_LO +: SLOT_W];
          tmo_zero_nxt = (in_tdata[IN_TMO_LO +: TMO_W] == '0);
          dl_nxt       = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
          state_nxt    = S_DISP;
        end
      end

      // Decode the request and start a scan where one is needed
      S_DISP: begin
        status_nxt  = ST_DONE;
        changed_nxt = 1'b0;
        moved_nxt   = 1'b0;
        if (op_r == OP_REMOVE) begin
          if (!queued_r[tag_r]) begin
            status_nxt = ST_NOT_QUEUED;
            state_nxt  = S_HRD;
          end else begin
            changed_nxt = (head_r == tag_r);
            state_nxt   = S_UNLINK;
          end
        end else if (tmo_zero_r) begin
          status_nxt = ST_ZERO_TMO;
          state_nxt  = S_HRD;
        end else begin
          ram_we = 1'b1;
          if (queued_r[tag_r]) begin
            changed_nxt = (head_r == tag_r);
            if (lk_rd.nv) begin
              pend_nxt  = lk_rd.nxt;
              ram_raddr = lk_rd.nxt;
              state_nxt = S_FSCAN;
            end else begin
              state_nxt = S_HRD;
            end
          end else if (empty_r) begin
            state_nxt = S_LHEAD;
          end else begin
            pend_nxt  = tail_r;
            ram_raddr = tail_r;
            state_nxt = S_BSCAN;
          end
        end
      end

      // Walk toward the tail past entries not later than the new deadline
      S_FSCAN: begin
        if (ram_rdata > dl_r) begin
          state_nxt = moved_r ? S_UNLINK : S_HRD;
        end else begin
          moved_nxt = 1'b1;
          last_nxt  = pend_r;
          if (!lk_rd.nv) begin
            state_nxt = S_UNLINK;
          end else begin
            pend_nxt  = lk_rd.nxt;
            ram_raddr = lk_rd.nxt;
          end
        end
      end

      // Walk from the tail toward the head for the insertion point
      S_BSCAN: begin
        if (ram_rdata <= dl_r) begin
          last_nxt  = pend_r;
          state_nxt = S_LAFTER;
        end else if (!lk_rd.pv) begin
          state_nxt = S_LHEAD;
        end else begin
          pend_nxt  = lk_rd.prv;
          ram_raddr = lk_rd.prv;
        end
      end

      // Drop the slot from the list
      S_UNLINK: begin
        if (lk_rd.pv) begin
          lk_nxt[lk_rd.prv].nxt = lk_rd.nxt;
          lk_nxt[lk_rd.prv].nv  = lk_rd.nv;
        end else begin
          head_nxt = lk_rd.nxt;
        end
        if (lk_rd.nv) begin
          lk_nxt[lk_rd.nxt].prv = lk_rd.prv;
          lk_nxt[lk_rd.nxt].pv  = lk_rd.pv;
        end else begin
          tail_nxt = lk_rd.prv;
        end
        if (!lk_rd.pv && !lk_rd.nv) begin
          empty_nxt = 1'b1;
          head_nxt  = '0;
          tail_nxt  = '0;
        end
        queued_nxt[tag_r] = 1'b0;
        state_nxt = (op_r == OP_REMOVE) ? S_HRD : S_LAFTER;
      end

      // Insert the slot after last_r
      S_LAFTER: begin
        lk_nxt[last_r].nxt = tag_r;
        lk_nxt[last_r].nv  = 1'b1;
        lk_nxt[tag_r].prv  = last_r;
        lk_nxt[tag_r].pv   = 1'b1;
        lk_nxt[tag_r].nxt  = lk_rd.nxt;
        lk_nxt[tag_r].nv   = lk_rd.nv;
        if (lk_rd.nv) begin
          lk_nxt[lk_rd.nxt].prv = tag_r;
        end else begin
          tail_nxt = tag_r;
        end
        queued_nxt[tag_r] = 1'b1;
        empty_nxt         = 1'b0;
        state_nxt         = S_HRD;
      end

      // Insert the slot at the head
      S_LHEAD: begin
        changed_nxt       = 1'b1;
        lk_nxt[tag_r].pv  = 1'b0;
        lk_nxt[tag_r].prv = '0;
        if (empty_r) begin
          lk_nxt[tag_r].nv  = 1'b0;
          lk_nxt[tag_r].nxt = '0;
          tail_nxt          = tag_r;
        end else begin
          lk_nxt[tag_r].nv   = 1'b1;
          lk_nxt[tag_r].nxt  = head_r;
          lk_nxt[head_r].prv = tag_r;
          lk_nxt[head_r].pv  = 1'b1;
        end
        head_nxt          = tag_r;
        empty_nxt         = 1'b0;
        queued_nxt[tag_r] = 1'b1;
        state_nxt         = S_HRD;
      end

      // Fetch the head deadline
      S_HRD: begin
        state_nxt = S_FIN;
      end

      // Load the result once the output register is free
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[OUT_BITS-1:0] = empty_r
            ? {{(TIME_BITS + SLOT_W + 1){1'b0}}, changed_r, status_r}
            : {ram_rdata, head_r, 1'b1, changed_r, status_r};
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      queued_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      queued_r    <= queued_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and link registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tag_r      <= tag_nxt;
    tmo_zero_r <= tmo_zero_nxt;
    dl_r       <= dl_nxt;
    pend_r     <= pend_nxt;
    last_r     <= last_nxt;
    moved_r    <= moved_nxt;
    status_r   <= status_nxt;
    changed_r  <= changed_nxt;
    lk_r       <= lk_nxt;
    out_data_r <= out_data_nxt;
  end

  // An empty queue holds no slot
  a_empty_none_queued: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (queued_r == '0))
    else $error("empty queue with queued slots");

  // A nonempty queue has queued slots at both ends
  a_ends_queued: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> (queued_r[head_r] && queued_r[tail_r]))
    else $error("head or tail slot not queued");

  // A finished request lands in the output register and frees the input
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || out_tready))
      |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded");

endmodule

[rtl/dstq_ram.sv]
// ----------------------------------------------------------------------------
// dstq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No reset on contents.
// ----------------------------------------------------------------------------
module dstq_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
